### rtl/core/cmst_pkg.sv
// ----------------------------------------------------------------------------
// cmst_pkg
// Shared types and constants of the compare match system timer: access kinds,
// register map codes, widths and the result bundle of the update stage.
// ----------------------------------------------------------------------------
package cmst_pkg;

	localparam int DATA_W       = 32;
	localparam int KIND_W       = 2;
	localparam int IDX_W        = 3;
	localparam int MAX_COMPARES = 4;
	localparam int NUM_COMPARES = 4;

	// flag field of the status register
	localparam logic [MAX_COMPARES-1:0] FLAG_FIELD = 4'hF;

	// access kinds
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

	// register map
	localparam logic [IDX_W-1:0] REG_STATUS = 3'd0;
	localparam logic [IDX_W-1:0] REG_LOW    = 3'd1;
	localparam logic [IDX_W-1:0] REG_HIGH   = 3'd2;
	localparam logic [IDX_W-1:0] REG_CMP0   = 3'd3;
	localparam logic [IDX_W-1:0] REG_CMP3   = 3'd6;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              bus_error;
		logic              irq;
	} result_t;

endpackage

### rtl/core/cmst_core.sv
// ----------------------------------------------------------------------------
// cmst_core
// Timer state and its update: counter increment with carry, compare match,
// status clear, compare writes, register reads and bus error decode.
// ----------------------------------------------------------------------------
module cmst_core #(
	parameter int NUM_COMPARES = cmst_pkg::NUM_COMPARES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [cmst_pkg::KIND_W-1:0]       kind,
	input  logic [cmst_pkg::IDX_W-1:0]        reg_index,
	input  logic [cmst_pkg::DATA_W-1:0]       write_data,
	output cmst_pkg::result_t                 res
);

	localparam logic [NUM_COMPARES-1:0] FLAG_MASK =
		cmst_pkg::FLAG_FIELD[NUM_COMPARES-1:0];

	logic [cmst_pkg::DATA_W-1:0] count_low_q;
	logic [cmst_pkg::DATA_W-1:0] count_high_q;
	logic [cmst_pkg::DATA_W-1:0] compare_q [NUM_COMPARES];
	logic [NUM_COMPARES-1:0]     flags_q;

	logic                        is_tick;
	logic                        is_read;
	logic                        is_write;
	logic [cmst_pkg::DATA_W-1:0] low_inc;
	logic                        low_carry;
	logic [cmst_pkg::DATA_W-1:0] low_d;
	logic [cmst_pkg::DATA_W-1:0] high_d;
	logic [NUM_COMPARES-1:0]     flags_d;
	logic [cmst_pkg::IDX_W-1:0]  cmp_sel;
	logic                        cmp_range;
	logic [NUM_COMPARES-1:0]     cmp_hit;
	logic                        cmp_ok;
	logic [cmst_pkg::DATA_W-1:0] cmp_rd;
	logic [cmst_pkg::DATA_W-1:0] rd;
	logic                        err;

	assign is_tick  = (kind == cmst_pkg::KIND_TICK);
	assign is_read  = (kind == cmst_pkg::KIND_READ);
	assign is_write = (kind == cmst_pkg::KIND_WRITE);

	assign {low_carry, low_inc} = {1'b0, count_low_q} + {{cmst_pkg::DATA_W{1'b0}}, 1'b1};

	assign cmp_sel   = reg_index - cmst_pkg::REG_CMP0;
	assign cmp_range = (reg_index >= cmst_pkg::REG_CMP0) && (reg_index <= cmst_pkg::REG_CMP3);

	always_comb begin
		cmp_rd = '0;
		for (int i = 0; i < NUM_COMPARES; i++) begin
			cmp_hit[i] = cmp_range && (cmp_sel == 3'(i));
			cmp_rd     = cmp_rd | ({cmst_pkg::DATA_W{cmp_hit[i]}} & compare_q[i]);
		end
	end

	assign cmp_ok = |cmp_hit;

	// next counter and flag values
	always_comb begin
		low_d   = count_low_q;
		high_d  = count_high_q;
		flags_d = flags_q;
		if (is_tick) begin
			low_d  = low_inc;
			high_d = count_high_q + {{(cmst_pkg::DATA_W-1){1'b0}}, low_carry};
			for (int i = 0; i < NUM_COMPARES; i++) begin
				if ((low_inc != '0) && (low_inc == compare_q[i]))
					flags_d[i] = 1'b1;
			end
		end else if (is_write && (reg_index == cmst_pkg::REG_STATUS)) begin
			flags_d = flags_q & ~(write_data[NUM_COMPARES-1:0] & FLAG_MASK);
		end
	end

	// read mux and error decode
	always_comb begin
		rd  = '0;
		err = 1'b0;
		if (is_read) begin
			priority if (reg_index == cmst_pkg::REG_STATUS)
				rd = {{(cmst_pkg::DATA_W-NUM_COMPARES){1'b0}}, flags_q & FLAG_MASK};
			else if (reg_index == cmst_pkg::REG_LOW)
				rd = count_low_q;
			else if (reg_index == cmst_pkg::REG_HIGH)
				rd = count_high_q;
			else if (cmp_ok)
				rd = cmp_rd;
			else
				err = 1'b1;
		end else if (is_write) begin
			err = !((reg_index == cmst_pkg::REG_STATUS) || cmp_ok);
		end
	end

	assign res.read_data = rd;
	assign res.bus_error = err;
	assign res.irq       = |flags_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_low_q  <= '0;
			count_high_q <= '0;
			flags_q      <= '0;
			for (int i = 0; i < NUM_COMPARES; i++)
				compare_q[i] <= '0;
		end else if (en) begin
			count_low_q  <= low_d;
			count_high_q <= high_d;
			flags_q      <= flags_d;
			for (int i = 0; i < NUM_COMPARES; i++) begin
				if (is_write && cmp_hit[i])
					compare_q[i] <= write_data;
			end
		end
	end

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		en && is_tick |=> count_low_q == $past(count_low_q) + 1'b1)
		else $error("counter low word did not advance on tick");

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && is_tick) |=> $stable(count_low_q) && $stable(count_high_q))
		else $error("counter changed without a tick");

	a_flags_set_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && is_tick) |=> (flags_q & ~$past(flags_q)) == '0)
		else $error("match flag set without a tick");

endmodule

### rtl/core/compare_match_system_timer.sv
// ----------------------------------------------------------------------------
// compare_match_system_timer
// 64-bit timer advanced by tick beats, with compare match flags and a register port.
// ----------------------------------------------------------------------------
// One input channel (in_valid, in_stall) carries kind, reg_index and
// write_data: a timer tick, a register read or a register write. Every beat
// yields exactly one result beat on the output channel (out_valid,
// out_stall) with read_data, bus_error and irq, in input order.
// A beat accepted into the input register is processed against the timer
// state by cmst_core; its result is registered in the output register and
// shows on the outputs from there. One beat per cycle is sustained while
// out_stall is low, as cmst_core adds and compares combinationally.
// While out_stall holds a waiting result, the input register still takes a
// beat if it is empty; once it is full too, in_stall rises in the same cycle.
// Reset clears the counter, compare registers, match flags and both valid
// bits; results come out in order with none lost when the receiver stalls.
// irq in a result is the flag state after that beat's update.
// ----------------------------------------------------------------------------
module compare_match_system_timer #(
	parameter int NUM_COMPARES = cmst_pkg::NUM_COMPARES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cmst_pkg::KIND_W-1:0] kind,
	input  logic [cmst_pkg::IDX_W-1:0]  reg_index,
	input  logic [cmst_pkg::DATA_W-1:0] write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cmst_pkg::DATA_W-1:0] read_data,
	output logic                        bus_error,
	output logic                        irq
);

	logic                        valid_s1;
	logic [cmst_pkg::KIND_W-1:0] kind_s1;
	logic [cmst_pkg::IDX_W-1:0]  reg_index_s1;
	logic [cmst_pkg::DATA_W-1:0] write_data_s1;
	logic                        advance;
	logic                        fire;
	cmst_pkg::result_t           res;
	cmst_pkg::result_t           res_s2;
	logic                        valid_s2;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1       <= kind;
			reg_index_s1  <= reg_index;
			write_data_s1 <= write_data;
		end
	end

	cmst_core #(
		.NUM_COMPARES(NUM_COMPARES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (fire),
		.kind      (kind_s1),
		.reg_index (reg_index_s1),
		.write_data(write_data_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign read_data = res_s2.read_data;
	assign bus_error = res_s2.bus_error;
	assign irq       = res_s2.irq;

endmodule
